>>> hw/rtl/sal_pkg.sv
// sal_pkg: shared types, widths and state codes of the suffix array builder
// used by the interfaces, the build engine and the top level
`default_nettype none

package sal_pkg;

  localparam int MAX_LEN = 16384;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;

  localparam logic [SYM_W-1:0] SYMBOL_MAX_RST = 8'hFF;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE,
    S_IN_A, S_IN_B,
    S_CLR,
    S_CNT_A, S_CNT_B, S_CNT_C, S_CNT_D,
    S_PFX_A, S_PFX_B,
    S_DST_A, S_DST_B, S_DST_C, S_DST_D,
    S_RND, S_TAIL, S_SHF_A, S_SHF_B,
    S_RK_A, S_RK_B, S_RK_C, S_RK_D,
    S_CPY_A, S_CPY_B, S_CHK,
    S_INV_A, S_INV_B, S_LZ,
    S_LA, S_LB, S_LC,
    S_CA, S_CB, S_CC,
    S_DONE
  } build_state_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } build_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } build_stat_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [SYM_W-1:0] data;
  } sym_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } qry_rd_t;

  typedef struct packed {
    logic [IDX_W-1:0] order;
    logic [IDX_W-1:0] lcp;
  } qry_data_t;

endpackage

`default_nettype wire

>>> hw/rtl/sal_in_if.sv
// sal_in_if: request channel (load or query item) with valid/ready
// depends on sal_pkg for field widths
`default_nettype none

interface sal_in_if import sal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic [IDX_W-1:0] rank_index;

  modport source (output valid, mode, symbol, last, rank_index, input ready);
  modport sink   (input valid, mode, symbol, last, rank_index, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sal_out_if.sv
// sal_out_if: result channel of query items with valid/ready
// depends on sal_pkg for field widths
`default_nettype none

interface sal_out_if import sal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] suffix_start;
  logic [IDX_W-1:0] lcp;
  logic             valid_res;

  modport source (output valid, suffix_start, lcp, valid_res, input ready);
  modport sink   (input valid, suffix_start, lcp, valid_res, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sal_ram.sv
// sal_ram: generic single write, single read ram with registered read
// no dependencies
`default_nettype none

module sal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sal_engine.sv
// sal_engine: memories plus build sequencer (prefix doubling, kasai lcp)
// depends on sal_pkg and sal_ram
`default_nettype none

module sal_engine import sal_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SYM_W-1:0] symbol_max,
  input  wire build_ctl_t       ctl,
  input  wire sym_wr_t          load_wr,
  input  wire qry_rd_t          qry_rd,
  output qry_data_t             qry_data,
  output build_stat_t           stat
);

  build_state_t st, st_next;

  logic [LEN_W-1:0] n, i, p, l, acc, k;
  logic [IDX_W-1:0] top, v, s, cur, prev, rc, rp, rpl, r, j;
  logic [SYM_W-1:0] sa;
  logic             in_round;

  // memory ports
  logic             sym_we, sym_re;
  logic [IDX_W-1:0] sym_waddr, sym_raddr;
  logic [SYM_W-1:0] sym_wdata, sym_rdata;
  logic             ord_we, ord_re;
  logic [IDX_W-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic             rnk_we, rnk_re;
  logic [IDX_W-1:0] rnk_waddr, rnk_raddr, rnk_wdata, rnk_rdata;
  logic             scr_we, scr_re;
  logic [IDX_W-1:0] scr_waddr, scr_raddr, scr_wdata, scr_rdata;
  logic             bkt_we, bkt_re;
  logic [IDX_W-1:0] bkt_waddr, bkt_raddr;
  logic [LEN_W-1:0] bkt_wdata, bkt_rdata;
  logic             lcp_we, lcp_re;
  logic [IDX_W-1:0] lcp_waddr, lcp_raddr, lcp_wdata, lcp_rdata;

  sal_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_sym (
    .clk, .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
    .re(sym_re), .raddr(sym_raddr), .rdata(sym_rdata));
  sal_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_ord (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .re(ord_re), .raddr(ord_raddr), .rdata(ord_rdata));
  sal_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_rnk (
    .clk, .we(rnk_we), .waddr(rnk_waddr), .wdata(rnk_wdata),
    .re(rnk_re), .raddr(rnk_raddr), .rdata(rnk_rdata));
  sal_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_scr (
    .clk, .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .re(scr_re), .raddr(scr_raddr), .rdata(scr_rdata));
  sal_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_bkt (
    .clk, .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .re(bkt_re), .raddr(bkt_raddr), .rdata(bkt_rdata));
  sal_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_lcp (
    .clk, .we(lcp_we), .waddr(lcp_waddr), .wdata(lcp_wdata),
    .re(lcp_re), .raddr(lcp_raddr), .rdata(lcp_rdata));

  function automatic logic [IDX_W-1:0] clamp_key(input logic [IDX_W-1:0] key,
                                                 input logic [IDX_W-1:0] lim);
    return (key > lim) ? lim : key;
  endfunction

  localparam int XW = LEN_W - IDX_W;

  logic [IDX_W-1:0] i_idx, p_idx, key_c, top_new;
  logic [LEN_W-1:0] top_ext, i_m1, ord_ext, shf_val, pfx_sum, bkt_dec;
  logic [LEN_W:0]   cur_l, prev_l, n_ext, ik, jk;
  logic             rk_diff, cmp_ok;

  always_comb begin
    i_idx   = i[IDX_W-1:0];
    p_idx   = p[IDX_W-1:0];
    key_c   = clamp_key(rnk_rdata, top);
    top_ext = {{XW{1'b0}}, top};
    i_m1    = i - 1'b1;
    ord_ext = {{XW{1'b0}}, ord_rdata};
    shf_val = ord_ext - l;
    pfx_sum = bkt_rdata + acc;
    bkt_dec = bkt_rdata - 1'b1;
    n_ext   = {1'b0, n};
    cur_l   = {1'b0, {XW{1'b0}}, cur} + {1'b0, l};
    prev_l  = {1'b0, {XW{1'b0}}, prev} + {1'b0, l};
    // a suffix running past the end never matches its neighbor
    rk_diff = (rc != rp) || (prev_l >= n_ext) || (cur_l >= n_ext) || (rnk_rdata != rpl);
    top_new = (i != '0 && rk_diff) ? top + 1'b1 : top;
    ik      = {1'b0, i} + {1'b0, k};
    jk      = {1'b0, {XW{1'b0}}, j} + {1'b0, k};
    cmp_ok  = (ik < n_ext) && (jk < n_ext);
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:  if (ctl.start) st_next = S_IN_A;
      S_IN_A:  st_next = (i == n) ? S_CLR : S_IN_B;
      S_IN_B:  st_next = S_IN_A;
      S_CLR:   if (i == top_ext) st_next = S_CNT_A;
      S_CNT_A: st_next = (i == n) ? S_PFX_A : S_CNT_B;
      S_CNT_B: st_next = S_CNT_C;
      S_CNT_C: st_next = S_CNT_D;
      S_CNT_D: st_next = S_CNT_A;
      S_PFX_A: st_next = (i > top_ext) ? S_DST_A : S_PFX_B;
      S_PFX_B: st_next = S_PFX_A;
      S_DST_A: begin
        if (i != '0) st_next = S_DST_B;
        else st_next = in_round ? S_RK_A : S_RND;
      end
      S_DST_B: st_next = S_DST_C;
      S_DST_C: st_next = S_DST_D;
      S_DST_D: st_next = S_DST_A;
      S_RND:   st_next = (l < n) ? S_TAIL : S_INV_A;
      S_TAIL:  if (i == n) st_next = S_SHF_A;
      S_SHF_A: st_next = (i == n) ? S_CLR : S_SHF_B;
      S_SHF_B: st_next = S_SHF_A;
      S_RK_A:  st_next = (i == n) ? S_CPY_A : S_RK_B;
      S_RK_B:  st_next = S_RK_C;
      S_RK_C:  st_next = S_RK_D;
      S_RK_D:  st_next = S_RK_A;
      S_CPY_A: st_next = (i == n) ? S_CHK : S_CPY_B;
      S_CPY_B: st_next = S_CPY_A;
      S_CHK:   st_next = (top_ext >= n - 1'b1) ? S_INV_A : S_RND;
      S_INV_A: st_next = (i == n) ? S_LZ : S_INV_B;
      S_INV_B: st_next = S_INV_A;
      S_LZ:    st_next = S_LA;
      S_LA:    st_next = (i == n) ? S_DONE : S_LB;
      S_LB:    st_next = (rnk_rdata != '0) ? S_LC : S_LA;
      S_LC:    st_next = S_CA;
      S_CA:    st_next = cmp_ok ? S_CB : S_LA;
      S_CB:    st_next = S_CC;
      S_CC:    st_next = (sym_rdata == sa) ? S_CA : S_LA;
      S_DONE:  st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    sym_we = 1'b0; sym_waddr = '0; sym_wdata = '0; sym_re = 1'b0; sym_raddr = '0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_re = 1'b0; ord_raddr = '0;
    rnk_we = 1'b0; rnk_waddr = '0; rnk_wdata = '0; rnk_re = 1'b0; rnk_raddr = '0;
    scr_we = 1'b0; scr_waddr = '0; scr_wdata = '0; scr_re = 1'b0; scr_raddr = '0;
    bkt_we = 1'b0; bkt_waddr = '0; bkt_wdata = '0; bkt_re = 1'b0; bkt_raddr = '0;
    lcp_we = 1'b0; lcp_waddr = '0; lcp_wdata = '0; lcp_re = 1'b0; lcp_raddr = '0;
    stat.done = 1'b0;
    stat.busy = (st != S_IDLE);
    unique case (st)
      S_IDLE: begin
        sym_we = load_wr.we; sym_waddr = load_wr.addr; sym_wdata = load_wr.data;
        ord_re = qry_rd.re;  ord_raddr = qry_rd.addr;
        lcp_re = qry_rd.re;  lcp_raddr = qry_rd.addr;
      end
      S_IN_A: if (i != n) begin
        sym_re = 1'b1; sym_raddr = i_idx;
        scr_we = 1'b1; scr_waddr = i_idx; scr_wdata = i_idx;
      end
      S_IN_B: begin
        rnk_we = 1'b1; rnk_waddr = i_idx;
        rnk_wdata = {{(IDX_W-SYM_W){1'b0}}, sym_rdata};
      end
      S_CLR: begin
        bkt_we = 1'b1; bkt_waddr = i_idx; bkt_wdata = '0;
      end
      S_CNT_A: if (i != n) begin
        scr_re = 1'b1; scr_raddr = i_idx;
      end
      S_CNT_B: begin
        rnk_re = 1'b1; rnk_raddr = scr_rdata;
      end
      S_CNT_C: begin
        bkt_re = 1'b1; bkt_raddr = key_c;
      end
      S_CNT_D: begin
        bkt_we = 1'b1; bkt_waddr = v; bkt_wdata = bkt_rdata + 1'b1;
      end
      S_PFX_A: if (i <= top_ext) begin
        bkt_re = 1'b1; bkt_raddr = i_idx;
      end
      S_PFX_B: begin
        bkt_we = 1'b1; bkt_waddr = i_idx; bkt_wdata = pfx_sum;
      end
      S_DST_A: if (i != '0) begin
        scr_re = 1'b1; scr_raddr = i_m1[IDX_W-1:0];
      end
      S_DST_B: begin
        rnk_re = 1'b1; rnk_raddr = scr_rdata;
      end
      S_DST_C: begin
        bkt_re = 1'b1; bkt_raddr = key_c;
      end
      S_DST_D: begin
        bkt_we = 1'b1; bkt_waddr = v; bkt_wdata = bkt_dec;
        ord_we = 1'b1; ord_waddr = bkt_dec[IDX_W-1:0]; ord_wdata = s;
      end
      S_TAIL: if (i != n) begin
        scr_we = 1'b1; scr_waddr = p_idx; scr_wdata = i_idx;
      end
      S_SHF_A: if (i != n) begin
        ord_re = 1'b1; ord_raddr = i_idx;
      end
      S_SHF_B: if (ord_ext >= l) begin
        scr_we = 1'b1; scr_waddr = p_idx; scr_wdata = shf_val[IDX_W-1:0];
      end
      S_RK_A: if (i != n) begin
        ord_re = 1'b1; ord_raddr = i_idx;
      end
      S_RK_B: begin
        rnk_re = 1'b1; rnk_raddr = ord_rdata;
      end
      S_RK_C: begin
        rnk_re = 1'b1; rnk_raddr = cur_l[IDX_W-1:0];
      end
      S_RK_D: begin
        scr_we = 1'b1; scr_waddr = cur; scr_wdata = top_new;
      end
      S_CPY_A: if (i != n) begin
        scr_re = 1'b1; scr_raddr = i_idx;
      end
      S_CPY_B: begin
        rnk_we = 1'b1; rnk_waddr = i_idx; rnk_wdata = scr_rdata;
      end
      S_INV_A: if (i != n) begin
        ord_re = 1'b1; ord_raddr = i_idx;
      end
      S_INV_B: begin
        rnk_we = 1'b1; rnk_waddr = ord_rdata; rnk_wdata = i_idx;
      end
      S_LZ: begin
        lcp_we = 1'b1; lcp_waddr = '0; lcp_wdata = '0;
      end
      S_LA: if (i != n) begin
        rnk_re = 1'b1; rnk_raddr = i_idx;
      end
      S_LB: if (rnk_rdata != '0) begin
        ord_re = 1'b1; ord_raddr = rnk_rdata - 1'b1;
      end
      S_CA: begin
        if (cmp_ok) begin
          sym_re = 1'b1; sym_raddr = ik[IDX_W-1:0];
        end else begin
          lcp_we = 1'b1; lcp_waddr = r; lcp_wdata = k[IDX_W-1:0];
        end
      end
      S_CB: begin
        sym_re = 1'b1; sym_raddr = jk[IDX_W-1:0];
      end
      S_CC: if (sym_rdata != sa) begin
        lcp_we = 1'b1; lcp_waddr = r; lcp_wdata = k[IDX_W-1:0];
      end
      S_DONE: stat.done = 1'b1;
      default: ;
    endcase
  end

  assign qry_data.order = ord_rdata;
  assign qry_data.lcp   = lcp_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: if (ctl.start) begin
        n <= ctl.len; i <= '0; l <= {{(LEN_W-1){1'b0}}, 1'b1};
        in_round <= 1'b0; top <= {{(IDX_W-SYM_W){1'b0}}, symbol_max};
      end
      S_IN_A:  if (i == n) i <= '0;
      S_IN_B:  i <= i + 1'b1;
      S_CLR:   i <= (i == top_ext) ? '0 : i + 1'b1;
      S_CNT_A: if (i == n) begin
        i <= '0; acc <= '0;
      end
      S_CNT_C: v <= key_c;
      S_CNT_D: i <= i + 1'b1;
      S_PFX_A: if (i > top_ext) i <= n;
      S_PFX_B: begin
        acc <= pfx_sum; i <= i + 1'b1;
      end
      S_DST_A: if (i == '0 && in_round) top <= '0;
      S_DST_B: s <= scr_rdata;
      S_DST_C: v <= key_c;
      S_DST_D: i <= i_m1;
      S_RND: begin
        if (l < n) begin
          p <= '0; i <= n - l;
        end else begin
          i <= '0;
        end
      end
      S_TAIL: begin
        if (i == n) begin
          i <= '0;
        end else begin
          p <= p + 1'b1; i <= i + 1'b1;
        end
      end
      S_SHF_A: if (i == n) begin
        i <= '0; in_round <= 1'b1;
      end
      S_SHF_B: begin
        if (ord_ext >= l) p <= p + 1'b1;
        i <= i + 1'b1;
      end
      S_RK_A:  if (i == n) i <= '0;
      S_RK_B:  cur <= ord_rdata;
      S_RK_C:  rc <= rnk_rdata;
      S_RK_D: begin
        top <= top_new; prev <= cur; rp <= rc; rpl <= rnk_rdata; i <= i + 1'b1;
      end
      S_CPY_B: i <= i + 1'b1;
      S_CHK: begin
        if (top_ext >= n - 1'b1) i <= '0;
        else l <= {l[LEN_W-2:0], 1'b0};
      end
      S_INV_B: i <= i + 1'b1;
      S_LZ: begin
        i <= '0; k <= '0;
      end
      S_LB: begin
        r <= rnk_rdata;
        if (k != '0) k <= k - 1'b1;
        if (rnk_rdata == '0) i <= i + 1'b1;
      end
      S_LC: j <= ord_rdata;
      S_CA: if (!cmp_ok) i <= i + 1'b1;
      S_CB: sa <= sym_rdata;
      S_CC: begin
        if (sym_rdata == sa) k <= k + 1'b1;
        else i <= i + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/suffix_array_lcp_builder_core.sv
// suffix_array_lcp_builder_core: load/query front end, result register, build engine
// a query result passes the read stage, then the output register, after its item is accepted; loads give none
// throughput: one load or query item per cycle while ready is high; the last load starts a build
//   that holds ready low through the first sort, each doubling round and then kasai,
//   serialized by the single read port of each memory (every step is a dependent read);
//   a query waiting on a stalled output also holds ready low
// reset: synchronous, clears control state and sets symbol_max to 255; no clearing pass
`default_nettype none

module suffix_array_lcp_builder_core import sal_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [SYM_W-1:0] cfg_wdata,
  sal_in_if.sink                req,
  sal_out_if.source             rsp
);

  // configuration register
  logic [SYM_W-1:0] symbol_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_max <= SYMBOL_MAX_RST;
    end else if (cfg_we) begin
      symbol_max <= cfg_wdata;
    end
  end

  // string state
  logic [LEN_W-1:0] len, len_base, len_next;
  logic             built;

  // query read stage: data comes back from the memories in the cycle after accept
  logic s1_valid, s1_ok, s1_move;

  build_ctl_t  ctl;
  build_stat_t stat;
  sym_wr_t     load_wr;
  qry_rd_t     qry_rd;
  qry_data_t   qry_data;

  logic accept, acc_load, acc_query, room;
  logic [SYM_W-1:0] sym_sat;

  assign s1_move   = !rsp.valid || rsp.ready;
  // input held while a build runs, or while a query read waits on a stalled output
  assign req.ready = !stat.busy && (!s1_valid || s1_move);
  assign accept    = req.valid && req.ready;
  assign acc_load  = accept && (req.mode == MODE_LOAD);
  assign acc_query = accept && (req.mode == MODE_QUERY);

  // a load after a build begins a new string
  assign len_base = built ? '0 : len;
  assign room     = (len_base < LEN_W'(MAX_LEN));
  assign len_next = len_base + {{(LEN_W-1){1'b0}}, room};
  assign sym_sat  = (req.symbol > symbol_max) ? symbol_max : req.symbol;

  // symbols beyond capacity are dropped, a last flag still builds
  assign load_wr.we   = acc_load && room;
  assign load_wr.addr = len_base[IDX_W-1:0];
  assign load_wr.data = sym_sat;

  assign ctl.start = acc_load && req.last;
  assign ctl.len   = len_next;

  assign qry_rd.re   = acc_query;
  assign qry_rd.addr = req.rank_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      built <= 1'b0;
    end else begin
      if (acc_load) begin
        len   <= len_next;
        built <= 1'b0;
      end else if (stat.done) begin
        built <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc_query) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // validity judged at accept time against the string then held
  always_ff @(posedge clk) begin
    if (acc_query) begin
      s1_ok <= built && ({{(LEN_W-IDX_W){1'b0}}, req.rank_index} < len);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_valid && s1_move) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_move) begin
      rsp.suffix_start <= s1_ok ? qry_data.order : '0;
      rsp.lcp          <= s1_ok ? qry_data.lcp : '0;
      rsp.valid_res    <= s1_ok;
    end
  end

  sal_engine u_engine (
    .clk,
    .rst,
    .symbol_max,
    .ctl,
    .load_wr,
    .qry_rd,
    .qry_data,
    .stat
  );

  // no item is taken while the engine owns the memories
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !req.ready)
    else $error("item accepted during build");

  // a last load always starts a build on the next cycle
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (acc_load && req.last) |=> stat.busy)
    else $error("build did not start");

  // a finished build marks the array as present
  a_done_built: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> built)
    else $error("built flag not set after build");

  // an accepted query always occupies the read stage next cycle
  a_query_staged: assert property (@(posedge clk) disable iff (rst)
    acc_query |=> s1_valid)
    else $error("query item lost");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench of suffix_array_lcp_builder_core, suffix order by prefix
// doubling and lcp by kasai, predicted per item; depends on sal_pkg, sal_in_if, sal_out_if
`timescale 1ns / 1ps

module tb_top;
  import sal_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000000;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SYM_W-1:0] cfg_wdata;

  sal_in_if  req_if ();
  sal_out_if rsp_if ();

  suffix_array_lcp_builder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // one predicted query answer
  typedef struct {
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] lcp;
    logic             ok;
  } query_answer_t;

  query_answer_t answer_q[$];

  // predictor state: string, suffix order, ranks, scratch, bucket counts, lcp
  int unsigned text_mem  [MAX_LEN];
  int unsigned order_mem [MAX_LEN];
  int unsigned rank_mem  [MAX_LEN];
  int unsigned work_mem  [MAX_LEN];
  int unsigned bucket_mem[MAX_LEN + 256];
  int unsigned height_mem[MAX_LEN];
  int unsigned text_len;
  bit          have_array;
  int unsigned sym_limit;

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int answers_seen;
  int loads_sent;
  int queries_sent;
  int builds_done;
  int quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // stable counting sort of work_mem by rank_mem into order_mem
  function automatic void counting_pass(int unsigned n, int unsigned top);
    int unsigned i;
    int unsigned v;
    int unsigned s;
    if (top >= MAX_LEN + 256) top = MAX_LEN + 255;
    for (i = 0; i <= top; i++) bucket_mem[i] = 0;
    for (i = 0; i < n; i++) begin
      v = rank_mem[work_mem[i] % MAX_LEN];
      if (v > top) v = top;
      bucket_mem[v]++;
    end
    for (i = 1; i <= top; i++) bucket_mem[i] += bucket_mem[i-1];
    for (i = n; i > 0; i--) begin
      s = work_mem[i-1];
      v = rank_mem[s % MAX_LEN];
      if (v > top) v = top;
      bucket_mem[v]--;
      order_mem[bucket_mem[v] % MAX_LEN] = s;
    end
  endfunction

  // prefix doubling for the order, then kasai for the heights
  function automatic void build_arrays(int unsigned n);
    int unsigned i, span, top, p, cur, prv, r, k, j;
    top = sym_limit;
    for (i = 0; i < n; i++) begin
      work_mem[i] = i;
      rank_mem[i] = text_mem[i];
    end
    counting_pass(n, top);
    for (span = 1; span < n; span <<= 1) begin
      p = 0;
      for (i = n - span; i < n; i++) work_mem[p++] = i;
      for (i = 0; i < n; i++)
        if (order_mem[i] >= span && p < MAX_LEN) work_mem[p++] = order_mem[i] - span;
      counting_pass(n, top);
      top = 0;
      for (i = 0; i < n; i++) begin
        cur = order_mem[i];
        if (i > 0) begin
          prv = order_mem[i-1];
          if (rank_mem[cur] != rank_mem[prv]) top++;
          else if (prv + span >= n || cur + span >= n) top++;
          else if (rank_mem[cur+span] != rank_mem[prv+span]) top++;
        end
        work_mem[cur] = top;
      end
      for (i = 0; i < n; i++) rank_mem[i] = work_mem[i];
      if (top >= n - 1) break;
    end
    for (i = 0; i < n; i++) rank_mem[order_mem[i] % MAX_LEN] = i;
    height_mem[0] = 0;
    k = 0;
    for (i = 0; i < n; i++) begin
      r = rank_mem[i];
      if (k > 0) k--;
      if (r != 0 && r < n) begin
        j = order_mem[r-1];
        while (i + k < n && j + k < n && text_mem[i+k] == text_mem[j+k]) k++;
        height_mem[r] = k;
      end
    end
  endfunction

  // advance the predictor by one accepted item
  function automatic void predict_item(bit m, int unsigned s, bit lst, int unsigned ri);
    query_answer_t a;
    if (m == MODE_LOAD) begin
      if (have_array) begin
        have_array = 0;
        text_len   = 0;
      end
      if (text_len < MAX_LEN) begin
        text_mem[text_len] = (s > sym_limit) ? sym_limit : s;
        text_len++;
      end
      if (lst) begin
        build_arrays(text_len);
        have_array = 1;
        builds_done++;
      end
    end else begin
      if (have_array && ri < text_len) begin
        a.start = order_mem[ri];
        a.lcp   = height_mem[ri];
        a.ok    = 1'b1;
      end else begin
        a.start = '0;
        a.lcp   = '0;
        a.ok    = 1'b0;
      end
      answer_q.push_back(a);
    end
  endfunction

  // drive one item at the falling edge, hold until accepted
  task automatic send_item(bit m, int unsigned s, bit lst, int unsigned ri);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.mode       = m;
    req_if.symbol     = s[SYM_W-1:0];
    req_if.last       = lst;
    req_if.rank_index = ri[IDX_W-1:0];
    do @(posedge clk); while (!req_if.ready);
    if (m == MODE_LOAD) loads_sent++;
    else queries_sent++;
    predict_item(m, s, lst, ri);
  endtask

  task automatic load_symbol(int unsigned s, bit lst);
    send_item(MODE_LOAD, s, lst, $urandom_range(MAX_LEN - 1));
  endtask

  task automatic query_rank(int unsigned ri);
    send_item(MODE_QUERY, $urandom_range(255), $urandom_range(1), ri);
  endtask

  task automatic bus_idle();
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  // a query is taken only once any build is over, so its answer marks the block idle
  task automatic wait_answers();
    bus_idle();
    while (answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic settle_block();
    query_rank(0);
    wait_answers();
  endtask

  task automatic write_symbol_max(int unsigned v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v[SYM_W-1:0];
    @(negedge clk);
    cfg_we    = 1'b0;
    sym_limit = v & 8'hFF;
  endtask

  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d (answer %0d)",
                 field, want, got, answers_seen);
    end
  endtask

  // receiver: stall pattern set at the falling edge
  always @(negedge clk) begin
    rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // result check and watchdog at the rising edge
  always @(posedge clk) begin
    query_answer_t a;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (rsp_if.valid && rsp_if.ready) begin
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected answer: start %0d lcp %0d valid %0d",
                     rsp_if.suffix_start, rsp_if.lcp, rsp_if.valid_res);
        end else begin
          a = answer_q.pop_front();
          report_field("suffix_start", a.start, rsp_if.suffix_start);
          report_field("lcp", a.lcp, rsp_if.lcp);
          report_field("valid_res", a.ok, rsp_if.valid_res);
        end
        answers_seen++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // edge cases: queries before a build, a known word, symbol range extremes, out of range ranks
  task automatic test_directed();
    int unsigned word[6];
    int unsigned i;
    word = '{8'h62, 8'h61, 8'h6E, 8'h61, 8'h6E, 8'h61};
    query_rank(0);
    query_rank(MAX_LEN - 1);
    for (i = 0; i < 6; i++) load_symbol(word[i], i == 5);
    for (i = 0; i < 7; i++) query_rank(i);
    query_rank(MAX_LEN - 1);
    // extremes of the symbol range
    load_symbol(8'hFF, 0);
    load_symbol(8'h00, 0);
    load_symbol(8'hFF, 1);
    query_rank(1);
    query_rank(2);
    // loads without last leave no array to query
    load_symbol(8'h10, 0);
    query_rank(0);
    settle_block();
  endtask

  // saturation against small symbol limits, including zero
  task automatic test_symbol_limits();
    int unsigned i, n;
    write_symbol_max(3);
    n = 9;
    for (i = 0; i < n; i++) load_symbol($urandom_range(255), i == n - 1);
    for (i = 0; i < n; i++) query_rank(i);
    settle_block();
    write_symbol_max(0);
    n = 7;
    for (i = 0; i < n; i++) load_symbol($urandom_range(1, 255), i == n - 1);
    for (i = 0; i < n; i++) query_rank(i);
    settle_block();
    write_symbol_max(255);
  endtask

  // random strings with queries; alphabets vary so repeats and deep rounds show up
  task automatic test_random_phase(int idle_pct, int stall_pct, int unsigned limit,
                                   int unsigned budget);
    int unsigned sent, n, i, style, alpha;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    settle_block();
    write_symbol_max(limit);
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) == 0) wait_answers();
      style = $urandom_range(9);
      n = ($urandom_range(19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      alpha = (style < 3) ? 2 : (style < 6) ? 5 : 256;
      for (i = 0; i < n; i++) begin
        if (style == 9) load_symbol(i % 3 == 0 ? 8'hFF : 8'h01, i == n - 1);
        else load_symbol($urandom_range(alpha - 1), i == n - 1);
      end
      sent += n;
      if ($urandom_range(7) == 0) begin
        load_symbol($urandom_range(255), 0);
        query_rank($urandom_range(3));
        sent += 2;
      end
      for (i = 0; i < n + 2; i++) begin
        if ($urandom_range(9) == 0) query_rank($urandom_range(MAX_LEN - 1));
        else query_rank($urandom_range(n));
      end
      sent += n + 2;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_LOAD;
    req_if.symbol = '0;
    req_if.last = 1'b0;
    req_if.rank_index = '0;
    rsp_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    answers_seen = 0;
    loads_sent = 0;
    queries_sent = 0;
    builds_done = 0;
    quiet_cycles = 0;
    text_len = 0;
    have_array = 0;
    sym_limit = SYMBOL_MAX_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    write_symbol_max(255);
    test_symbol_limits();
    test_random_phase(0, 0, 255, 300);
    test_random_phase(75, 0, 1, 300);
    test_random_phase(0, 75, $urandom_range(2, 254), 300);
    test_random_phase(36, 36, 255, 300);

    wait_answers();
    repeat (20) @(posedge clk);
    $display("covered %0d loads, %0d queries, %0d builds; %0d answers checked",
             loads_sent, queries_sent, builds_done, answers_seen);
    $display("symbol limits 0, 1, 3 and 255, out of range ranks, sender and receiver stalls");
    if (errors == 0 && answer_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sal_pkg.sv
hw/rtl/sal_in_if.sv
hw/rtl/sal_out_if.sv
hw/rtl/sal_ram.sv
hw/rtl/sal_engine.sv
hw/rtl/suffix_array_lcp_builder_core.sv
tb/sv/tb_top.sv
